// ===== sv/bmpd_pkg.sv =====
`timescale 1ns / 1ps
package bmpd_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int Q_DEPTH        = 2;

  localparam logic [3:0] ST_PIXEL       = 4'd0;
  localparam logic [3:0] ST_SIGNATURE   = 4'd1;
  localparam logic [3:0] ST_HDR_SIZE    = 4'd2;
  localparam logic [3:0] ST_PLANES      = 4'd3;
  localparam logic [3:0] ST_BPP         = 4'd4;
  localparam logic [3:0] ST_COMPRESSED  = 4'd5;
  localparam logic [3:0] ST_WIDTH       = 4'd6;
  localparam logic [3:0] ST_HEIGHT_ZERO = 4'd7;
  localparam logic [3:0] ST_HEIGHT_MIN  = 4'd8;
  localparam logic [3:0] ST_OFFSET      = 4'd9;
  localparam logic [3:0] ST_TOO_LARGE   = 4'd10;
  localparam logic [3:0] ST_TRUNCATED   = 4'd11;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_PAD,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [11:0] column;
    logic [11:0] pixel_row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        final_pixel;
  } out_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [11:0] column;
    logic [11:0] src_row;
    logic [11:0] height_low;
    logic        bottom_up;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/bmpd_front.sv =====
`timescale 1ns / 1ps
module bmpd_front import bmpd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  in_t  item,
  output logic push,
  output cmd_t cmd
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  localparam logic [5:0]  POS_SIG    = 6'd0;
  localparam logic [5:0]  POS_OFFSET = 6'd10;
  localparam logic [5:0]  POS_INFO   = 6'd14;
  localparam logic [5:0]  POS_WIDTH  = 6'd18;
  localparam logic [5:0]  POS_HEIGHT = 6'd22;
  localparam logic [5:0]  POS_PLANES = 6'd26;
  localparam logic [5:0]  POS_DEPTH  = 6'd28;
  localparam logic [5:0]  POS_COMP   = 6'd30;
  localparam logic [5:0]  LEN_HALF   = 6'd2;
  localparam logic [5:0]  LEN_WORD   = 6'd4;
  localparam logic [31:0] HEADER_BYTES = 32'd54;
  localparam logic [31:0] FILE_HDR_BYTES = 32'd14;
  localparam logic [15:0] BMP_MAGIC  = 16'h4D42;
  localparam logic [31:0] INFO_BYTES = 32'd40;
  localparam logic [15:0] BPP_24     = 16'd24;

  function automatic logic in_field(logic [5:0] pos, logic [5:0] start, logic [5:0] len);
    in_field = (pos >= start) && (pos < start + len);
  endfunction

  function automatic logic [1:0] lane(logic [5:0] pos, logic [5:0] start);
    lane = 2'(pos - start);
  endfunction

  phase_t        phase, phase_next;
  logic [31:0]   byte_count, byte_count_next;
  logic [15:0]   signature_word, signature_word_next;
  logic [31:0]   data_offset, data_offset_next;
  logic [31:0]   info_size, info_size_next;
  logic [31:0]   width_word, width_word_next;
  logic [31:0]   height_word, height_word_next;
  logic [15:0]   planes_word, planes_word_next;
  logic [15:0]   depth_word, depth_word_next;
  logic [31:0]   compression_word, compression_word_next;
  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] line_count, line_count_next;
  logic [1:0]    pixel_byte_index, pixel_byte_index_next;
  logic [7:0]    blue_hold, blue_hold_next;
  logic [7:0]    green_hold, green_hold_next;
  logic [1:0]    padding_left, padding_left_next;

  phase_t      eff_phase;
  logic [31:0] eff_count;
  logic [5:0]  hc;
  logic [31:0] abs_height;
  logic [3:0]  chk;
  logic        last;
  logic [1:0]  pad_dec;
  logic [7:0]  b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
    byte_count       <= byte_count_next;
    signature_word   <= signature_word_next;
    data_offset      <= data_offset_next;
    info_size        <= info_size_next;
    width_word       <= width_word_next;
    height_word      <= height_word_next;
    planes_word      <= planes_word_next;
    depth_word       <= depth_word_next;
    compression_word <= compression_word_next;
    column_count     <= column_count_next;
    line_count       <= line_count_next;
    pixel_byte_index <= pixel_byte_index_next;
    blue_hold        <= blue_hold_next;
    green_hold       <= green_hold_next;
    padding_left     <= padding_left_next;
  end

  assign abs_height = height_word[31] ? (32'd0 - height_word) : height_word;

  always_comb begin
    if (signature_word != BMP_MAGIC) begin
      chk = ST_SIGNATURE;
    end else if (info_size != INFO_BYTES) begin
      chk = ST_HDR_SIZE;
    end else if (planes_word != 16'd1) begin
      chk = ST_PLANES;
    end else if (depth_word != BPP_24) begin
      chk = ST_BPP;
    end else if (compression_word != 32'd0) begin
      chk = ST_COMPRESSED;
    end else if (width_word == 32'd0 || width_word[31]) begin
      chk = ST_WIDTH;
    end else if (height_word == 32'd0) begin
      chk = ST_HEIGHT_ZERO;
    end else if (height_word == 32'h8000_0000) begin
      chk = ST_HEIGHT_MIN;
    end else if ({1'b0, data_offset} < {1'b0, FILE_HDR_BYTES} + {1'b0, info_size}) begin
      chk = ST_OFFSET;
    end else if (width_word > 32'(MAX_WIDTH) || abs_height > 32'(MAX_HEIGHT)) begin
      chk = ST_TOO_LARGE;
    end else begin
      chk = ST_PIXEL;
    end
  end

  always_comb begin
    b         = item.data_byte;
    eff_phase = item.start_of_file ? PH_HEADER : phase;
    eff_count = item.start_of_file ? 32'd0 : byte_count;
    hc        = eff_count[5:0];
    last      = (32'(line_count) + 32'd1 >= abs_height) &&
                (32'(column_count) + 32'd1 >= width_word);
    pad_dec   = (padding_left != 2'd0) ? padding_left - 2'd1 : 2'd0;

    phase_next            = phase;
    byte_count_next       = byte_count;
    signature_word_next   = signature_word;
    data_offset_next      = data_offset;
    info_size_next        = info_size;
    width_word_next       = width_word;
    height_word_next      = height_word;
    planes_word_next      = planes_word;
    depth_word_next       = depth_word;
    compression_word_next = compression_word;
    column_count_next     = column_count;
    line_count_next       = line_count;
    pixel_byte_index_next = pixel_byte_index;
    blue_hold_next        = blue_hold;
    green_hold_next       = green_hold;
    padding_left_next     = padding_left;

    push = 1'b0;
    cmd  = '0;

    if (accept) begin
      if (item.start_of_file) begin
        phase_next            = PH_HEADER;
        byte_count_next       = '0;
        signature_word_next   = '0;
        data_offset_next      = '0;
        info_size_next        = '0;
        width_word_next       = '0;
        height_word_next      = '0;
        planes_word_next      = '0;
        depth_word_next       = '0;
        compression_word_next = '0;
        column_count_next     = '0;
        line_count_next       = '0;
        pixel_byte_index_next = '0;
        blue_hold_next        = '0;
        green_hold_next       = '0;
        padding_left_next     = '0;
      end

      if (eff_phase != PH_IDLE && eff_phase != PH_HALT) begin
        if (item.end_of_stream) begin
          push       = 1'b1;
          cmd.status = ST_TRUNCATED;
          phase_next = PH_HALT;
        end else begin
          unique case (eff_phase)
            PH_HEADER: begin
              if (in_field(hc, POS_SIG, LEN_HALF))
                signature_word_next[8*lane(hc, POS_SIG) +: 8] = b;
              if (in_field(hc, POS_OFFSET, LEN_WORD))
                data_offset_next[8*lane(hc, POS_OFFSET) +: 8] = b;
              if (in_field(hc, POS_INFO, LEN_WORD))
                info_size_next[8*lane(hc, POS_INFO) +: 8] = b;
              if (in_field(hc, POS_WIDTH, LEN_WORD))
                width_word_next[8*lane(hc, POS_WIDTH) +: 8] = b;
              if (in_field(hc, POS_HEIGHT, LEN_WORD))
                height_word_next[8*lane(hc, POS_HEIGHT) +: 8] = b;
              if (in_field(hc, POS_PLANES, LEN_HALF))
                planes_word_next[8*lane(hc, POS_PLANES) +: 8] = b;
              if (in_field(hc, POS_DEPTH, LEN_HALF))
                depth_word_next[8*lane(hc, POS_DEPTH) +: 8] = b;
              if (in_field(hc, POS_COMP, LEN_WORD))
                compression_word_next[8*lane(hc, POS_COMP) +: 8] = b;
              byte_count_next = eff_count + 32'd1;
              if (eff_count + 32'd1 == HEADER_BYTES) begin
                if (chk != ST_PIXEL) begin
                  push       = 1'b1;
                  cmd.status = chk;
                  phase_next = PH_HALT;
                end else begin
                  phase_next = (HEADER_BYTES < data_offset) ? PH_SKIP : PH_PIXELS;
                end
              end
            end
            PH_SKIP: begin
              byte_count_next = byte_count + 32'd1;
              if (byte_count + 32'd1 >= data_offset) phase_next = PH_PIXELS;
            end
            PH_PAD: begin
              padding_left_next = pad_dec;
              if (pad_dec == 2'd0) phase_next = PH_PIXELS;
            end
            PH_PIXELS: begin
              if (pixel_byte_index == 2'd0) begin
                blue_hold_next        = b;
                pixel_byte_index_next = 2'd1;
              end else if (pixel_byte_index == 2'd1) begin
                green_hold_next       = b;
                pixel_byte_index_next = 2'd2;
              end else begin
                pixel_byte_index_next = 2'd0;
                push           = 1'b1;
                cmd.status     = ST_PIXEL;
                cmd.column     = 12'(column_count);
                cmd.src_row    = 12'(line_count);
                cmd.height_low = abs_height[11:0];
                cmd.bottom_up  = !height_word[31];
                cmd.red        = b;
                cmd.green      = green_hold;
                cmd.blue       = blue_hold;
                cmd.last       = last;
                if (last) begin
                  phase_next = PH_HALT;
                end else if (32'(column_count) + 32'd1 >= width_word) begin
                  column_count_next = '0;
                  line_count_next   = line_count + RW'(1);
                  padding_left_next = width_word[1:0];
                  if (width_word[1:0] != 2'd0) phase_next = PH_PAD;
                end else begin
                  column_count_next = column_count + CW'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

endmodule

// ===== sv/bmpd_queue.sv =====
`timescale 1ns / 1ps
module bmpd_queue import bmpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int NW = $clog2(Q_DEPTH + 1);

  cmd_t          entries [Q_DEPTH];
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [NW-1:0] fill, fill_next;

  function automatic logic [AW-1:0] bump(logic [AW-1:0] p);
    bump = (32'(p) == Q_DEPTH - 1) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
    if (push) entries[wr_ptr] <= cmd;
  end

  always_comb begin
    wr_ptr_next = push ? bump(wr_ptr) : wr_ptr;
    rd_ptr_next = pop ? bump(rd_ptr) : rd_ptr;
    fill_next   = fill + NW'(push) - NW'(pop);
  end

  assign head         = entries[rd_ptr];
  assign status.full  = (32'(fill) == Q_DEPTH);
  assign status.empty = (fill == '0);

endmodule

// ===== sv/bmpd_back.sv =====
`timescale 1ns / 1ps
module bmpd_back import bmpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t head,
  input  logic head_valid,
  output logic pop,
  output out_t result,
  output logic result_valid,
  input  logic result_ready
);

  out_t formatted;
  logic result_valid_next;

  assign pop = head_valid && (!result_valid || result_ready);

  always_comb begin
    formatted.status      = head.status;
    formatted.column      = head.column;
    formatted.pixel_row   = head.bottom_up ?
                            (head.height_low - 12'd1 - head.src_row) : head.src_row;
    formatted.red         = head.red;
    formatted.green       = head.green;
    formatted.blue        = head.blue;
    formatted.final_pixel = head.last;
    result_valid_next     = pop ? 1'b1 : (result_ready ? 1'b0 : result_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
    if (pop) result <= formatted;
  end

endmodule

// ===== sv/bmp24_stream_decoder.sv =====
`timescale 1ns / 1ps
// A result is written to a queue entry and then to the output register before it is valid.
// Throughput: one byte per clock while the queue is not full, set by the byte-serial header/pixel parser; the
//   header check is done in the cycle of byte 54 without stopping the stream.
// A two-entry queue and an output register decouple the parser from result stalls.
// Reset (rst, synchronous): parser idle until start_of_file, queue and output empty.
module bmp24_stream_decoder import bmpd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  in_t  item,
  output logic result_valid,
  input  logic result_ready,
  output out_t result
);

  logic      accept;
  logic      q_push;
  logic      q_pop;
  cmd_t      q_in;
  cmd_t      q_head;
  q_status_t q_status;

  assign item_ready = !q_status.full;
  assign accept     = item_valid && item_ready;

  bmpd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (item),
    .push  (q_push),
    .cmd   (q_in)
  );

  bmpd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .cmd   (q_in),
    .pop   (q_pop),
    .head  (q_head),
    .status(q_status)
  );

  bmpd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .head_valid  (!q_status.empty),
    .pop         (q_pop),
    .result      (result),
    .result_valid(result_valid),
    .result_ready(result_ready)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("queue push while full");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    q_push |=> !q_status.empty)
    else $error("queue empty after push");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_PIXEL) |->
      (result.column == 12'd0 && result.pixel_row == 12'd0 && !result.final_pixel))
    else $error("error result carries pixel data");

  a_final_is_pixel: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.final_pixel) |-> (result.status == ST_PIXEL))
    else $error("final flag on non-pixel result");

endmodule
